// ===== rtl/box_blur_3x3_edge_replicate_top_macros.svh =====
// assertion macros for the box blur block
// clocked on clock, disabled during reset; used by bblur_back
`ifndef BOX_BLUR_3X3_EDGE_REPLICATE_TOP_MACROS_SVH
`define BOX_BLUR_3X3_EDGE_REPLICATE_TOP_MACROS_SVH

// same-cycle implication
`define BB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bblur_pkg.sv =====
// shared types, constants and helpers of the box blur block
// no dependencies
package bblur_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int ADDR_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WIDTH_W   = 11;
   localparam int HEIGHT_W  = 16;
   localparam int EW        = (ADDR_W + 1 > WIDTH_W) ? ADDR_W + 1 : WIDTH_W;
   localparam int CSR_W     = 16;

   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;
   localparam int QCNT_W    = 3;
   localparam int OUT_DEPTH = 4;
   localparam int OPTR_W    = 2;
   localparam int OCNT_W    = 3;

   // register indexes
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   // request kinds
   localparam logic MODE_PIXEL = 1'b0;
   localparam logic MODE_DRAIN = 1'b1;

   // ceil(65536 / 9), exact floor for sums up to 2295
   localparam logic [12:0] DIV9_RECIP = 13'd7282;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      pixel_type top;
      pixel_type mid;
      pixel_type bot;
   } column_type;

   // one line store entry: previous row and the row before it
   typedef struct packed {
      pixel_type above;
      pixel_type two;
   } entry_type;

   typedef struct packed {
      logic       is_drain;
      logic       shift;
      logic       emit_a;
      logic       emit_b;
      logic       sel_a_left;
      logic       sel_b_left;
      logic       run_a;
      logic       frame_a;
      column_type col;
   } job_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              empty;
   } qstat_type;

   typedef struct packed {
      logic [9:0] red;
      logic [9:0] green;
      logic [9:0] blue;
   } colsum_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       run_end;
      logic       frame_end;
   } result_type;

   function automatic colsum_type col_sum(column_type c);
      colsum_type s;
      s.red   = 10'(c.top.red)   + 10'(c.mid.red)   + 10'(c.bot.red);
      s.green = 10'(c.top.green) + 10'(c.mid.green) + 10'(c.bot.green);
      s.blue  = 10'(c.top.blue)  + 10'(c.mid.blue)  + 10'(c.bot.blue);
      return s;
   endfunction

   function automatic logic [7:0] div9(logic [11:0] s);
      logic [24:0] p;
      p = 25'(s) * 25'(DIV9_RECIP);
      return p[23:16];
   endfunction

endpackage

// ===== rtl/bblur_front.sv =====
// front end: registers, raster counters, line store and job issue
// depends on bblur_pkg
module bblur_front import bblur_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_mode,
   input  logic [7:0]       req_in_red,
   input  logic [7:0]       req_in_green,
   input  logic [7:0]       req_in_blue,
   input  qstat_type        qstat,
   output logic             q_push,
   output job_type          q_job
);

   logic [WIDTH_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0] height_ff;
   logic [ADDR_W-1:0]   col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [ADDR_W-1:0]   dcol_ff, dcol_in;
   logic                dok_ff, dok_in;
   logic [1:0]          seq_cnt_ff, seq_cnt_in;
   logic [ADDR_W-1:0]   seq_mid_ff, seq_mid_in, seq_next_ff, seq_next_in;
   logic                seq_last_ff, seq_last_in, seq_top_ff, seq_top_in;

   // b stage: read data returns, store write, column formed
   logic                b_valid_ff;
   logic                b_write_ff;
   logic [ADDR_W-1:0]   b_addr_ff;
   pixel_type           b_px_ff;
   logic                b_top_two_ff;
   job_type             b_job_ff;
   entry_type           rd_ff;
   entry_type           mem [MAX_WIDTH];

   logic [EW-1:0]       w_ext, eff_w;
   logic [ADDR_W-1:0]   wm1, d, d_prev, d_next;
   logic [HEIGHT_W-1:0] eff_h;
   logic                room, accept, row_end, d_last, reload;
   logic                iss_valid, iss_write, iss_top_two;
   logic [ADDR_W-1:0]   iss_addr;
   job_type             iss_job;
   entry_type           wdata;
   pixel_type           px;

   // effective frame size
   always_comb begin
      w_ext = EW'(width_ff);
      if (width_ff == '0) eff_w = EW'(1);
      else if (w_ext > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
      else eff_w = w_ext;
      wm1   = ADDR_W'(eff_w - EW'(1));
      eff_h = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
   end

   // drain column neighbors
   always_comb begin
      d      = (dcol_ff > wm1) ? wm1 : dcol_ff;
      d_last = (d >= wm1);
      d_prev = (d == '0) ? d : d - ADDR_W'(1);
      d_next = d_last ? d : d + ADDR_W'(1);
      reload = !dok_ff || (dcol_ff > wm1);
   end

   assign room     = ({1'b0, qstat.count} + (QCNT_W+1)'(b_valid_ff)) < (QCNT_W+1)'(QDEPTH);
   assign req_full = (seq_cnt_ff != 2'd0) || !room;
   assign accept   = req_push && !req_full;
   assign row_end  = (col_ff >= wm1);
   assign px       = '{red: req_in_red, green: req_in_green, blue: req_in_blue};

   // issue of one store read per cycle while the job queue has room, counter updates
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      dcol_in     = dcol_ff;
      dok_in      = dok_ff;
      seq_cnt_in  = seq_cnt_ff;
      seq_mid_in  = seq_mid_ff;
      seq_next_in = seq_next_ff;
      seq_last_in = seq_last_ff;
      seq_top_in  = seq_top_ff;
      iss_valid   = 1'b0;
      iss_write   = 1'b0;
      iss_addr    = col_ff;
      iss_top_two = 1'b0;
      iss_job     = '0;
      if (seq_cnt_ff != 2'd0) begin
         if (room) begin
            iss_valid      = 1'b1;
            iss_job.is_drain = 1'b1;
            iss_job.shift  = 1'b1;
            iss_job.run_a  = 1'b1;
            iss_top_two    = seq_top_ff;
            seq_cnt_in     = seq_cnt_ff - 2'd1;
            if (seq_cnt_ff == 2'd2) begin
               iss_addr = seq_mid_ff;
            end else begin
               iss_addr        = seq_next_ff;
               iss_job.emit_a  = 1'b1;
               iss_job.frame_a = seq_last_ff;
            end
         end
      end else if (accept) begin
         if (req_mode == MODE_PIXEL && row_ff < eff_h) begin
            iss_valid          = 1'b1;
            iss_write          = 1'b1;
            iss_addr           = col_ff;
            iss_top_two        = (row_ff >= HEIGHT_W'(2));
            iss_job.shift      = (row_ff != '0);
            iss_job.emit_a     = (row_ff != '0) && (col_ff != '0);
            iss_job.emit_b     = (row_ff != '0) && row_end;
            iss_job.sel_a_left = (col_ff >= ADDR_W'(2));
            iss_job.sel_b_left = (col_ff != '0);
            iss_job.run_a      = !row_end;
            dok_in             = 1'b0;
            if (row_end) begin
               col_in = '0;
               if ({1'b0, row_ff} + 17'd1 >= {1'b0, eff_h}) row_in = eff_h;
               else row_in = row_ff + HEIGHT_W'(1);
            end else begin
               col_in = col_ff + ADDR_W'(1);
            end
         end else if (req_mode == MODE_DRAIN && row_ff >= eff_h) begin
            iss_valid        = 1'b1;
            iss_job.is_drain = 1'b1;
            iss_job.shift    = 1'b1;
            iss_job.run_a    = 1'b1;
            iss_top_two      = (eff_h >= HEIGHT_W'(2));
            if (reload) begin
               iss_addr    = d_prev;
               seq_cnt_in  = 2'd2;
               seq_mid_in  = d;
               seq_next_in = d_next;
               seq_last_in = d_last;
               seq_top_in  = iss_top_two;
            end else begin
               iss_addr        = d_next;
               iss_job.emit_a  = 1'b1;
               iss_job.frame_a = d_last;
            end
            if (d_last) begin
               row_in  = '0;
               col_in  = '0;
               dcol_in = '0;
               dok_in  = 1'b0;
            end else begin
               dcol_in = d + ADDR_W'(1);
               dok_in  = 1'b1;
            end
         end
      end
      if (csr_we) dok_in = 1'b0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_W'(1024);
         height_ff  <= HEIGHT_W'(1024);
         col_ff     <= '0;
         row_ff     <= '0;
         dcol_ff    <= '0;
         dok_ff     <= 1'b0;
         seq_cnt_ff <= 2'd0;
         b_valid_ff <= 1'b0;
         b_write_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CSR_FRAME_WIDTH)  width_ff  <= csr_wdata[WIDTH_W-1:0];
         if (csr_we && csr_index == CSR_FRAME_HEIGHT) height_ff <= csr_wdata[HEIGHT_W-1:0];
         col_ff     <= col_in;
         row_ff     <= row_in;
         dcol_ff    <= dcol_in;
         dok_ff     <= dok_in;
         seq_cnt_ff <= seq_cnt_in;
         b_valid_ff <= iss_valid;
         b_write_ff <= iss_valid && iss_write;
      end
   end

   // payload registers of the drain sequence and b stage
   always_ff @(posedge clock) begin
      seq_mid_ff   <= seq_mid_in;
      seq_next_ff  <= seq_next_in;
      seq_last_ff  <= seq_last_in;
      seq_top_ff   <= seq_top_in;
      b_addr_ff    <= iss_addr;
      b_px_ff      <= px;
      b_top_two_ff <= iss_top_two;
      b_job_ff     <= iss_job;
   end

   assign wdata = '{above: b_px_ff, two: rd_ff.above};

   // line store: write from b stage, read with bypass of that write
   always_ff @(posedge clock) begin
      if (b_write_ff) mem[b_addr_ff] <= wdata;
      if (iss_valid) begin
         if (b_write_ff && b_addr_ff == iss_addr) rd_ff <= wdata;
         else rd_ff <= mem[iss_addr];
      end
   end

   // form the new window column
   always_comb begin
      q_push         = b_valid_ff;
      q_job          = b_job_ff;
      q_job.col.top  = b_top_two_ff ? rd_ff.two : rd_ff.above;
      q_job.col.mid  = rd_ff.above;
      q_job.col.bot  = b_job_ff.is_drain ? rd_ff.above : b_px_ff;
   end

endmodule

// ===== rtl/bblur_queue.sv =====
// short job queue between front and back end
// depends on bblur_pkg
module bblur_queue import bblur_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  job_type   push_job,
   input  logic      pop,
   output job_type   head_job,
   output qstat_type qstat
);

   job_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QCNT_W-1:0]   count_ff;

   assign head_job    = slot_ff[rd_ff];
   assign qstat.count = count_ff;
   assign qstat.empty = (count_ff == '0);

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + QPTR_W'(1);
         if (pop)  rd_ff <= rd_ff + QPTR_W'(1);
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

endmodule

// ===== rtl/bblur_back.sv =====
// back end: sliding windows, column sums, divide by nine, result queue
// depends on bblur_pkg and box_blur_3x3_edge_replicate_top_macros.svh
`include "box_blur_3x3_edge_replicate_top_macros.svh"
module bblur_back import bblur_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  job_type    head_job,
   input  qstat_type  qstat,
   output logic       q_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic       rsp_run_end,
   output logic       rsp_frame_end
);

   column_type pw_ff [3];
   column_type dw_ff [3];
   column_type pw_in [3];
   column_type dw_in [3];
   logic       phase_ff, phase_in, selb_ff, selb_in;

   logic       s1_valid_ff, s1_valid_in;
   colsum_type s1_l_ff, s1_m_ff, s1_r_ff;
   logic       s1_run_ff, s1_frame_ff, s1_run_in, s1_frame_in;
   column_type lc, mc, rc;

   result_type          ofifo_ff [OUT_DEPTH];
   logic [OPTR_W-1:0]   owr_ff, ord_ff;
   logic [OCNT_W-1:0]   ocnt_ff;
   logic                room, out_pop;
   result_type          res;
   logic [11:0]         tot_r, tot_g, tot_b;

   assign room = ({1'b0, ocnt_ff} + (OCNT_W+1)'(s1_valid_ff)) < (OCNT_W+1)'(OUT_DEPTH);

   // job execution: window shift and source selection
   always_comb begin
      pw_in       = pw_ff;
      dw_in       = dw_ff;
      phase_in    = phase_ff;
      selb_in     = selb_ff;
      q_pop       = 1'b0;
      s1_valid_in = 1'b0;
      s1_run_in   = 1'b1;
      s1_frame_in = 1'b0;
      lc          = pw_ff[2];
      mc          = pw_ff[2];
      rc          = pw_ff[2];
      if (room) begin
         if (phase_ff) begin
            // second result at row end
            phase_in    = 1'b0;
            s1_valid_in = 1'b1;
            lc          = selb_ff ? pw_ff[1] : pw_ff[2];
         end else if (!qstat.empty) begin
            q_pop = 1'b1;
            if (head_job.is_drain) begin
               dw_in[0] = dw_ff[1];
               dw_in[1] = dw_ff[2];
               dw_in[2] = head_job.col;
               lc       = dw_in[0];
               mc       = dw_in[1];
               rc       = dw_in[2];
               s1_valid_in = head_job.emit_a;
               s1_frame_in = head_job.frame_a;
            end else begin
               if (head_job.shift) begin
                  pw_in[0] = pw_ff[1];
                  pw_in[1] = pw_ff[2];
                  pw_in[2] = head_job.col;
               end
               if (head_job.emit_a) begin
                  s1_valid_in = 1'b1;
                  s1_run_in   = head_job.run_a;
                  lc          = head_job.sel_a_left ? pw_in[0] : pw_in[1];
                  mc          = pw_in[1];
                  rc          = pw_in[2];
                  phase_in    = head_job.emit_b;
                  selb_in     = head_job.sel_b_left;
               end else if (head_job.emit_b) begin
                  s1_valid_in = 1'b1;
                  lc          = head_job.sel_b_left ? pw_in[1] : pw_in[2];
                  mc          = pw_in[2];
                  rc          = pw_in[2];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
         pw_ff       <= '{default: '0};
         dw_ff       <= '{default: '0};
      end else begin
         phase_ff    <= phase_in;
         s1_valid_ff <= s1_valid_in;
         pw_ff       <= pw_in;
         dw_ff       <= dw_in;
      end
   end

   // column sums register
   always_ff @(posedge clock) begin
      selb_ff     <= selb_in;
      s1_l_ff     <= col_sum(lc);
      s1_m_ff     <= col_sum(mc);
      s1_r_ff     <= col_sum(rc);
      s1_run_ff   <= s1_run_in;
      s1_frame_ff <= s1_frame_in;
   end

   // nine-value totals and divide by nine
   always_comb begin
      tot_r         = 12'(s1_l_ff.red)   + 12'(s1_m_ff.red)   + 12'(s1_r_ff.red);
      tot_g         = 12'(s1_l_ff.green) + 12'(s1_m_ff.green) + 12'(s1_r_ff.green);
      tot_b         = 12'(s1_l_ff.blue)  + 12'(s1_m_ff.blue)  + 12'(s1_r_ff.blue);
      res.red       = div9(tot_r);
      res.green     = div9(tot_g);
      res.blue      = div9(tot_b);
      res.run_end   = s1_run_ff;
      res.frame_end = s1_frame_ff;
   end

   // result queue
   assign out_pop   = rsp_pop && (ocnt_ff != '0);
   assign rsp_empty = (ocnt_ff == '0);
   assign rsp_out_red   = ofifo_ff[ord_ff].red;
   assign rsp_out_green = ofifo_ff[ord_ff].green;
   assign rsp_out_blue  = ofifo_ff[ord_ff].blue;
   assign rsp_run_end   = ofifo_ff[ord_ff].run_end;
   assign rsp_frame_end = ofifo_ff[ord_ff].frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff  <= '0;
         ord_ff  <= '0;
         ocnt_ff <= '0;
      end else begin
         if (s1_valid_ff) owr_ff <= owr_ff + OPTR_W'(1);
         if (out_pop)     ord_ff <= ord_ff + OPTR_W'(1);
         ocnt_ff <= ocnt_ff + OCNT_W'(s1_valid_ff) - OCNT_W'(out_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) ofifo_ff[owr_ff] <= res;
   end

   `BB_ASSERT_IMP(a_out_no_overflow, s1_valid_ff, ocnt_ff < OCNT_W'(OUT_DEPTH) || out_pop, "result queue overflow")
   `BB_ASSERT_IMP(a_no_pop_in_phase, phase_ff, !q_pop, "job taken while second result pending")
   `BB_ASSERT_IMP(a_pop_nonempty, q_pop, !qstat.empty, "job queue popped while empty")
   `BB_ASSERT_NXT(a_phase_after_pop, q_pop && head_job.emit_a && head_job.emit_b && !head_job.is_drain, phase_ff, "row end result lost")

endmodule

// ===== rtl/box_blur_3x3_edge_replicate_top.sv =====
// 3x3 box blur with replicated edges, top level
// depends on bblur_pkg, bblur_front, bblur_queue, bblur_back
//
// usage:
//   request channel (req_push / req_full): one raster-order pixel per request,
//   or a drain tick (req_mode = 1) once the frame is in. accepted when push
//   is high and full is low. one request per cycle is taken while the job
//   queue has room; a drain tick that starts the flush of the final row, or
//   follows a register write, holds full while the line store is read for
//   its center and right columns.
//   result channel (rsp_empty / rsp_pop): blurred pixels, oldest first. the
//   last pixel of a row gives two results, one after the other. a result
//   reaches the result ports through the b stage, the job queue, the column
//   sums register and the result queue; results lag one row.
//   csr port: csr_we with csr_index (0 width, 1 height) and csr_wdata, one
//   write per cycle. the user must write only while the block is idle; the block does not enforce it.
//   reset: synchronous; counters, queues and windows clear, width and height
//   return to 1024. line store contents are not cleared.
//   stalls: a held result stops the back end when its queue fills; the job
//   queue then fills and full rises, no request is lost.
module box_blur_3x3_edge_replicate_top import bblur_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic             csr_index,
   input  logic [CSR_W-1:0] csr_wdata,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_mode,
   input  logic [7:0]       req_in_red,
   input  logic [7:0]       req_in_green,
   input  logic [7:0]       req_in_blue,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       rsp_out_red,
   output logic [7:0]       rsp_out_green,
   output logic [7:0]       rsp_out_blue,
   output logic             rsp_run_end,
   output logic             rsp_frame_end
);

   qstat_type qstat;
   logic      q_push, q_pop;
   job_type   q_job, head_job;

   bblur_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_push, .req_full, .req_mode, .req_in_red, .req_in_green, .req_in_blue,
      .qstat, .q_push, .q_job
   );

   bblur_queue u_queue (
      .clock, .reset, .push(q_push), .push_job(q_job), .pop(q_pop),
      .head_job, .qstat
   );

   bblur_back u_back (
      .clock, .reset, .head_job, .qstat, .q_pop,
      .rsp_pop, .rsp_empty, .rsp_out_red, .rsp_out_green, .rsp_out_blue,
      .rsp_run_end, .rsp_frame_end
   );

endmodule
